FILE: rtl/cem_pkg.sv
// Types, constants and codes shared by the cluster extent map block.
package cem_pkg;

  localparam int RUN_COUNT = 16;
  localparam int RUN_W     = (RUN_COUNT > 1) ? $clog2(RUN_COUNT) : 1;

  localparam int CLUSTER_W = 28;
  localparam int SECTOR_W  = 32;
  localparam int LOG2_W    = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CLUSTER_W-1:0] END_MARK = 28'hFFFFFF8;

  localparam logic [CFG_IDX_W-1:0] REG_DATA_START   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_LOG2 = 2'd1;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_LINK   = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_END      = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_MISS     = 2'd3
  } status_t;

  typedef struct packed {
    kind_t                kind;
    logic [CLUSTER_W-1:0] cluster_value;
    logic [SECTOR_W-1:0]  file_sector;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [SECTOR_W-1:0] card_sector;
  } rsp_t;

  // table write command broadcast to every cell
  typedef struct packed {
    logic                 clear;
    logic                 wr;
    logic                 ext;
    logic [RUN_W-1:0]     sel;
    logic [CLUSTER_W-1:0] first_index;
    logic [CLUSTER_W-1:0] end_index;
    logic [CLUSTER_W-1:0] first_cluster;
  } cell_cmd_t;

  // lookup query travelling down the chain
  typedef struct packed {
    logic                valid;
    logic                hit;
    logic [SECTOR_W-1:0] idx;
    logic [SECTOR_W-1:0] cl;
  } token_t;

endpackage

FILE: rtl/cem_cell.sv
// One extent table entry plus one stage of the lookup chain.
module cem_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [cem_pkg::RUN_W-1:0] id,
  input  cem_pkg::cell_cmd_t       cmd,
  input  cem_pkg::token_t          tok_in,
  output cem_pkg::token_t          tok_out
);
  import cem_pkg::*;

  logic [CLUSTER_W-1:0] first_index;
  logic [CLUSTER_W-1:0] end_index;
  logic [CLUSTER_W-1:0] first_cluster;
  logic                 selected;
  logic                 match;
  logic [SECTOR_W-1:0]  cl;

  assign selected = (cmd.sel == id);

  always_ff @(posedge clk) begin
    if (rst) begin
      first_index   <= '0;
      end_index     <= '0;
      first_cluster <= '0;
    end else if (cmd.wr && selected) begin
      first_index   <= cmd.first_index;
      end_index     <= cmd.end_index;
      first_cluster <= cmd.first_cluster;
    end else if (cmd.clear) begin
      first_index   <= '0;
      end_index     <= '0;
      first_cluster <= '0;
    end else if (cmd.ext && selected) begin
      end_index <= end_index + CLUSTER_W'(1);
    end
  end

  // empty runs never match; an earlier hit passes through untouched
  assign match = tok_in.valid && !tok_in.hit && (first_index != end_index)
                 && (tok_in.idx >= SECTOR_W'(first_index))
                 && (tok_in.idx <  SECTOR_W'(end_index));

  assign cl = tok_in.idx - SECTOR_W'(first_index) + SECTOR_W'(first_cluster)
              - SECTOR_W'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.idx <= tok_in.idx;
    tok_out.hit <= tok_in.hit || match;
    tok_out.cl  <= match ? cl : tok_in.cl;
  end

endmodule

FILE: rtl/cluster_extent_map_core.sv
// Cluster extent map: chain control, config registers and the cell row.
// Start and link words give their result in the cycle after acceptance; a lookup
// walks the row of RUN_COUNT cells one cell per cycle and its result is
// registered after the last cell. One word is in flight at a time; the
// next is taken in the cycle its predecessor's result is taken.
// Synchronous reset clears the table, chain state and config to defaults.
module cluster_extent_map_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  cem_pkg::req_t                req,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output cem_pkg::rsp_t                rsp,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cem_pkg::SECTOR_W-1:0]  cfg_data
);
  import cem_pkg::*;

  logic [SECTOR_W-1:0]  data_region_start;
  logic [LOG2_W-1:0]    cluster_size_log2;

  logic [RUN_W-1:0]     current_run;
  logic [RUN_W-1:0]     current_run_next;
  logic [CLUSTER_W-1:0] last_cluster;
  logic [CLUSTER_W-1:0] last_cluster_next;
  logic [CLUSTER_W-1:0] cur_end;
  logic [CLUSTER_W-1:0] cur_end_next;
  logic                 overflowed;
  logic                 overflowed_next;
  logic                 busy;
  logic [SECTOR_W-1:0]  q_off;

  logic                 accept;
  logic                 rsp_take;
  status_t              link_status;
  cell_cmd_t            cmd;
  token_t               tok [RUN_COUNT+1];
  logic [RUN_COUNT-1:0] tok_valid;
  logic [SECTOR_W-1:0]  off_mask;
  token_t               tail;

  assign cfg_ready = 1'b1;
  assign rsp_take  = rsp_valid && !rsp_stall;
  assign req_stall = busy && !rsp_take;
  assign accept    = req_valid && !req_stall;
  assign off_mask  = (SECTOR_W'(1) << cluster_size_log2) - SECTOR_W'(1);
  assign tail      = tok[RUN_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      data_region_start <= '0;
      cluster_size_log2 <= LOG2_W'(4);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DATA_START:   data_region_start <= cfg_data;
        REG_CLUSTER_LOG2: cluster_size_log2 <= cfg_data[LOG2_W-1:0];
        default: ;
      endcase
    end
  end

  // chain building
  always_comb begin
    current_run_next  = current_run;
    last_cluster_next = last_cluster;
    cur_end_next      = cur_end;
    overflowed_next   = overflowed;
    link_status       = ST_OK;
    cmd               = '0;
    cmd.sel           = current_run;
    if (accept) begin
      case (req.kind)
        KIND_START: begin
          cmd.clear         = 1'b1;
          cmd.wr            = 1'b1;
          cmd.sel           = '0;
          cmd.end_index     = CLUSTER_W'(1);
          cmd.first_cluster = req.cluster_value;
          current_run_next  = '0;
          last_cluster_next = req.cluster_value;
          cur_end_next      = CLUSTER_W'(1);
          overflowed_next   = 1'b0;
        end
        KIND_LINK: begin
          if (req.cluster_value >= END_MARK) begin
            link_status = ST_END;
          end else if (overflowed) begin
            link_status = ST_OVERFLOW;
          end else if ({1'b0, req.cluster_value}
                       == ({1'b0, last_cluster} + (CLUSTER_W+1)'(1))) begin
            cmd.ext           = 1'b1;
            last_cluster_next = req.cluster_value;
            cur_end_next      = cur_end + CLUSTER_W'(1);
          end else if (current_run == RUN_W'(RUN_COUNT - 1)) begin
            overflowed_next = 1'b1;
            link_status     = ST_OVERFLOW;
          end else begin
            cmd.wr            = 1'b1;
            cmd.sel           = current_run + RUN_W'(1);
            cmd.first_index   = cur_end;
            cmd.end_index     = cur_end + CLUSTER_W'(1);
            cmd.first_cluster = req.cluster_value;
            current_run_next  = current_run + RUN_W'(1);
            last_cluster_next = req.cluster_value;
            cur_end_next      = cur_end + CLUSTER_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_run  <= '0;
      last_cluster <= '0;
      cur_end      <= '0;
      overflowed   <= 1'b0;
    end else begin
      current_run  <= current_run_next;
      last_cluster <= last_cluster_next;
      cur_end      <= cur_end_next;
      overflowed   <= overflowed_next;
    end
  end

  // lookup query enters the head of the row
  assign tok[0] = {accept && (req.kind == KIND_LOOKUP), 1'b0,
                   req.file_sector >> cluster_size_log2, SECTOR_W'(0)};

  for (genvar i = 0; i < RUN_COUNT; i++) begin : g_cell
    cem_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .id      (RUN_W'(i)),
      .cmd     (cmd),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
    assign tok_valid[i] = tok[i+1].valid;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_off <= req.file_sector & off_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (rsp_take) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_take) begin
        rsp_valid <= 1'b0;
      end
      if ((accept && (req.kind != KIND_LOOKUP)) || tail.valid) begin
        rsp_valid <= 1'b1;
      end
    end
    if (accept && (req.kind != KIND_LOOKUP)) begin
      rsp.status      <= (req.kind == KIND_LINK) ? link_status : ST_OK;
      rsp.card_sector <= '0;
    end else if (tail.valid) begin
      rsp.status      <= tail.hit ? ST_OK : ST_MISS;
      rsp.card_sector <= tail.hit ? (data_region_start + (tail.cl << cluster_size_log2)
                                     + q_off) : '0;
    end
  end

  a_one_query: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_valid) <= 1)
    else $error("more than one lookup in the cell row");

  a_tail_busy: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> busy && !rsp_valid)
    else $error("lookup finished with no word in flight or result pending");

  a_run_range: assert property (@(posedge clk) disable iff (rst)
    current_run <= RUN_W'(RUN_COUNT - 1))
    else $error("current run beyond table");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    overflowed |-> current_run == RUN_W'(RUN_COUNT - 1))
    else $error("overflow flagged with free runs left");

  a_direct_rsp: assert property (@(posedge clk) disable iff (rst)
    accept && (req.kind != KIND_LOOKUP) |=> rsp_valid && !tok_valid[0])
    else $error("start or link word gave no result");

endmodule
